[sv/stream_pattern_masker_defines.svh]
// Assertion macros used by the checker file spm_checker.sv.
`ifndef STREAM_PATTERN_MASKER_DEFINES_SVH
`define STREAM_PATTERN_MASKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/spm_pkg.sv]
`default_nettype none

package spm_pkg;

	// Window geometry
	localparam int unsigned MAX_PATTERN = 16;
	localparam int unsigned WIN_W       = MAX_PATTERN * 8;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned IDX_W       = 4;

	// Masking character
	localparam logic [7:0] STAR_CHAR = 8'h2A;

	// Configuration register indexes
	localparam logic [1:0] REG_PATTERN_LEN  = 2'd0;
	localparam logic [1:0] REG_PATTERN_LOW  = 2'd1;
	localparam logic [1:0] REG_PATTERN_HIGH = 2'd2;

	// Input command codes
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	// One unit of output work: cnt words, all stars or bytes of data from the oldest up
	typedef struct packed {
		logic             star;
		logic [CNT_W-1:0] cnt;
		logic [WIN_W-1:0] data;
	} job_t;

endpackage

`default_nettype wire

[sv/spm_front.sv]
`default_nettype none

module spm_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [63:0]                cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       cmd,
	input  wire logic [7:0]                 in_byte,
	input  wire logic                       q_full,
	output logic                            push,
	output spm_pkg::job_t                   push_job
);

	logic [spm_pkg::CNT_W-1:0] pattern_len_q;
	logic [63:0]               pattern_low_q;
	logic [63:0]               pattern_high_q;
	logic [spm_pkg::WIN_W-1:0] window_q;
	logic [spm_pkg::CNT_W-1:0] fill_q;

	logic [spm_pkg::CNT_W-1:0] plen;
	logic [spm_pkg::WIN_W-1:0] pattern;
	logic [spm_pkg::WIN_W-1:0] app;
	logic [spm_pkg::WIN_W-1:0] mask;
	logic [spm_pkg::CNT_W-1:0] fill_inc;
	logic                      hit;
	logic                      accept;
	logic                      job_valid;
	spm_pkg::job_t             job;
	logic [spm_pkg::WIN_W-1:0] win_d;
	logic [spm_pkg::CNT_W-1:0] fill_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q  <= spm_pkg::CNT_W'(1);
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				spm_pkg::REG_PATTERN_LEN:  pattern_len_q  <= cfg_wdata[spm_pkg::CNT_W-1:0];
				spm_pkg::REG_PATTERN_LOW:  pattern_low_q  <= cfg_wdata;
				spm_pkg::REG_PATTERN_HIGH: pattern_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective pattern length, clamped to 1..MAX_PATTERN
	always_comb begin
		if (pattern_len_q == '0) begin
			plen = spm_pkg::CNT_W'(1);
		end else if (pattern_len_q > spm_pkg::CNT_W'(spm_pkg::MAX_PATTERN)) begin
			plen = spm_pkg::CNT_W'(spm_pkg::MAX_PATTERN);
		end else begin
			plen = pattern_len_q;
		end
	end

	assign pattern  = {pattern_high_q, pattern_low_q};
	assign mask     = ~({spm_pkg::WIN_W{1'b1}} << {plen, 3'b000});
	assign fill_inc = fill_q + spm_pkg::CNT_W'(1);

	// Window with the incoming byte placed after the held ones
	always_comb begin
		for (int i = 0; i < spm_pkg::MAX_PATTERN; i++) begin
			app[i*8 +: 8] = (fill_q == spm_pkg::CNT_W'(i)) ? in_byte : window_q[i*8 +: 8];
		end
	end

	assign hit = ((app ^ pattern) & mask) == '0;

	// Classify the word and work out the next window
	always_comb begin
		job_valid = 1'b0;
		job.star  = 1'b0;
		job.cnt   = spm_pkg::CNT_W'(1);
		job.data  = app;
		win_d     = window_q;
		fill_d    = fill_q;
		unique case (cmd)
			spm_pkg::CMD_FLUSH: begin
				job_valid = fill_q != '0;
				job.cnt   = fill_q;
				job.data  = window_q;
				fill_d    = '0;
			end
			spm_pkg::CMD_DATA: begin
				priority if (fill_inc < plen) begin
					win_d  = app;
					fill_d = fill_inc;
				end else if (hit) begin
					job_valid = 1'b1;
					job.star  = 1'b1;
					job.cnt   = plen;
					win_d     = app >> {plen, 3'b000};
					fill_d    = fill_inc - plen;
				end else begin
					job_valid = 1'b1;
					win_d     = app >> 8;
					fill_d    = fill_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && job_valid;
	assign push_job = job;

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_d;
		end
	end

	// Window bytes, only read below the fill count
	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= win_d;
		end
	end

endmodule

`default_nettype wire

[sv/spm_queue.sv]
`default_nettype none

module spm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire spm_pkg::job_t push_job,
	input  wire logic          pop,
	output logic               full,
	output logic               head_valid,
	output spm_pkg::job_t      head
);

	spm_pkg::job_t              slot_q [spm_pkg::QUEUE_DEPTH];
	logic [spm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [spm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [spm_pkg::QCNT_W-1:0] count_q;

	assign full       = count_q == spm_pkg::QCNT_W'(spm_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + spm_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + spm_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + spm_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - spm_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

[sv/spm_back.sv]
`default_nettype none

module spm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire spm_pkg::job_t head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               last
);

	logic [spm_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      last_q;

	logic                      load;
	logic                      is_last;
	logic [spm_pkg::WIN_W-1:0] sel;
	logic [7:0]                word;

	// Output register is free when empty or being taken
	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign is_last = idx_q == spm_pkg::IDX_W'(head.cnt - spm_pkg::CNT_W'(1));
	assign sel     = head.data >> {idx_q, 3'b000};
	assign word    = head.star ? spm_pkg::STAR_CHAR : sel[7:0];
	assign pop     = load && is_last;

	// Word index within the current job, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_last ? '0 : idx_q + spm_pkg::IDX_W'(1);
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= word;
			last_q     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

`default_nettype wire

[sv/stream_pattern_masker.sv]
// Byte stream masker: every occurrence of the configured pattern is replaced by '*'.
// Input channel: in_valid / in_stall with cmd and in_byte. cmd 0 carries a data byte,
// cmd 1 ends the stream and flushes the bytes still held in the window.
// Output channel: out_valid / out_stall with out_byte and last; last marks the final
// word caused by one input word. Data bytes that leave the window unresolved give none.
// Configuration: cfg_wr_en, cfg_index, cfg_wdata; index 0 pattern_len, 1 pattern bytes
// 0..7, 2 pattern bytes 8..15. Write only while no words are in flight.
// A result word enters the queue as its input word is taken, then the output register.
// Throughput: one input word per cycle while each yields at most one result word and the
// receiver does not stall; a match or a flush of N bytes gives N result words, sent by the
// single output register at one word per cycle while out_stall is low.
// A two-entry queue sits between the classifying front and the output back, so input
// is taken while a result waits; in_stall rises only when that queue is full.
// Receiver stall holds the output word steady and backs up into the queue.
// Reset: window empty, pattern_len 1, pattern bytes zero, no output pending.
`default_nettype none

module stream_pattern_masker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	logic          push;
	spm_pkg::job_t push_job;
	logic          pop;
	logic          q_full;
	logic          head_valid;
	spm_pkg::job_t head;

	spm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.in_byte   (in_byte),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	spm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	spm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule

`default_nettype wire

[sv/spm_checker.sv]
`default_nettype none
`include "stream_pattern_masker_defines.svh"

module spm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        last
);

	// Stalled output word holds
	`SPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last), "output word changed under stall")

	// Input backs up only behind pending output
	`SPM_ASSERT_NOW(a_stall_pending, in_stall, out_valid, "input stalled with no output pending")

	// Words of one burst follow without a gap
	`SPM_ASSERT_NEXT(a_burst_gapless, out_valid && !out_stall && !last, out_valid, "gap inside a result burst")

endmodule

bind stream_pattern_masker spm_checker u_spm_checker (.*);

`default_nettype wire
